@@ src/lir_pkg.sv @@
package lir_pkg;

    // Sequencer states of the interpolator
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_EMIT
    } lir_state_t;

    // Register index decoded from paddr[2]
    localparam logic REG_STEP = 1'b0;

endpackage

@@ src/linear_interp_resampler.sv @@
// Channel  | Direction | Beat contents (low bits first)              | Handshake
// s_       | in        | tdata: in_left, in_right, zero pad          | s_tvalid/s_tready
// m_       | out       | tdata: out_left, out_right, zero pad;       | m_tvalid/m_tready
//          |           | tuser: last_of_run                          |
// APB      | cfg       | step_q16 at byte address 0                  | psel/penable, pready=1
//
// The first frame after reset is only stored as the held frame. Every later frame
// yields up to MAX_OUTPUTS output beats, each computed by the serial shift-add multiplier,
// one fraction bit per cycle for both channels.
// A new frame is taken only in the idle state; m_tready low holds the output register and
// stalls the sequencer just before it would load the next beat.
// Reset: synchronous, active low; clears the step to 1.0, the held frame, phase and flags.
module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int FRAC_BITS   = 16,
    parameter int MAX_OUTPUTS = 8
) (
    input  logic aclk,
    input  logic aresetn,

    // in_left, in_right, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,

    // out_left, out_right, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    // last_of_run
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TDW     = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int PH_BITS = FRAC_BITS + 4;
    localparam int PH_W    = PH_BITS + 1;
    localparam int NW      = $clog2(MAX_OUTPUTS + 1);
    localparam int CW      = $clog2(FRAC_BITS);
    localparam int S       = SAMPLE_BITS;

    localparam logic [PH_W-1:0]    PH_ONE     = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_BITS-1:0] STEP_RESET = PH_BITS'(1) << FRAC_BITS;
    localparam logic [NW-1:0]      N_MAX      = NW'(MAX_OUTPUTS);
    localparam logic [CW-1:0]      CNT_LAST   = CW'(FRAC_BITS - 1);

    // Control and architectural state
    lir_state_t         state_reg, state_next;
    logic [PH_BITS-1:0] step_reg, step_next;
    logic [PH_BITS-1:0] phase_reg, phase_next;
    logic               have_prev_reg, have_prev_next;
    logic [PH_W-1:0]    ph_reg, ph_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [S-1:0]       prev_l_reg, prev_l_next;
    logic [S-1:0]       prev_r_reg, prev_r_next;

    // Datapath payload
    logic [S-1:0]         new_l_reg, new_l_next;
    logic [S-1:0]         new_r_reg, new_r_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [S:0]           diff_l_reg, diff_l_next;
    logic [S:0]           diff_r_reg, diff_r_next;
    logic [S+1:0]         acc_l_reg, acc_l_next;
    logic [S+1:0]         acc_r_reg, acc_r_next;
    logic [S-1:0]         out_l_reg, out_l_next;
    logic [S-1:0]         out_r_reg, out_r_next;
    logic                 out_last_reg, out_last_next;

    logic            cfg_wr;
    logic            in_beat;
    logic [S+1:0]    sum_l, sum_r;
    logic [PH_W-1:0] ph_add;
    logic [NW-1:0]   n_inc;

    // APB access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STEP);
    assign prdata = (paddr[2] == REG_STEP) ? 32'(step_reg) : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDW'({out_r_reg, out_l_reg});
    assign m_tuser  = out_last_reg;

    // One serial multiply step: add diff when the fraction bit is set, then shift right
    assign sum_l = acc_l_reg + (frac_reg[0] ? {diff_l_reg[S], diff_l_reg} : '0);
    assign sum_r = acc_r_reg + (frac_reg[0] ? {diff_r_reg[S], diff_r_reg} : '0);

    assign ph_add = ph_reg + PH_W'(step_reg);
    assign n_inc  = n_reg + NW'(1);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        step_next      = cfg_wr ? pwdata[PH_BITS-1:0] : step_reg;
        phase_next     = phase_reg;
        have_prev_next = have_prev_reg;
        ph_next        = ph_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        new_l_next     = new_l_reg;
        new_r_next     = new_r_reg;
        frac_next      = frac_reg;
        diff_l_next    = diff_l_reg;
        diff_r_next    = diff_r_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (!have_prev_reg) begin
                        prev_l_next    = s_tdata[S-1:0];
                        prev_r_next    = s_tdata[2*S-1:S];
                        have_prev_next = 1'b1;
                    end else begin
                        new_l_next = s_tdata[S-1:0];
                        new_r_next = s_tdata[2*S-1:S];
                        ph_next    = {1'b0, phase_reg};
                        n_next     = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (ph_reg < PH_ONE && n_reg < N_MAX) begin
                    frac_next   = ph_reg[FRAC_BITS-1:0];
                    diff_l_next = {new_l_reg[S-1], new_l_reg} - {prev_l_reg[S-1], prev_l_reg};
                    diff_r_next = {new_r_reg[S-1], new_r_reg} - {prev_r_reg[S-1], prev_r_reg};
                    acc_l_next  = '0;
                    acc_r_next  = '0;
                    cnt_next    = CNT_LAST;
                    state_next  = ST_MUL;
                end else begin
                    // End of frame: drop the phase by 1.0, saturating at zero
                    phase_next  = (ph_reg >= PH_ONE) ? PH_BITS'(ph_reg - PH_ONE) : '0;
                    prev_l_next = new_l_reg;
                    prev_r_next = new_r_reg;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL: begin
                acc_l_next = {sum_l[S+1], sum_l[S+1:1]};
                acc_r_next = {sum_r[S+1], sum_r[S+1:1]};
                frac_next  = frac_reg >> 1;
                cnt_next   = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Load the output register once it is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_l_next     = prev_l_reg + acc_l_reg[S-1:0];
                    out_r_next     = prev_r_reg + acc_r_reg[S-1:0];
                    out_last_next  = !(ph_add < PH_ONE && n_inc < N_MAX);
                    ph_next        = ph_add;
                    n_next         = n_inc;
                    state_next     = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            ph_reg        <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            have_prev_reg <= have_prev_next;
            out_valid_reg <= out_valid_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            ph_reg        <= ph_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        new_l_reg    <= new_l_next;
        new_r_reg    <= new_r_next;
        frac_reg     <= frac_next;
        diff_l_reg   <= diff_l_next;
        diff_r_reg   <= diff_r_next;
        acc_l_reg    <= acc_l_next;
        acc_r_reg    <= acc_r_next;
        out_l_reg    <= out_l_next;
        out_r_reg    <= out_r_next;
        out_last_reg <= out_last_next;
    end

    // Checks
    a_mul_frac_below_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (ph_reg < PH_ONE))
        else $error("multiply running with phase at or above 1.0");

    a_count_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        (n_reg <= N_MAX))
        else $error("output count beyond cap");

    a_frame_starts_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && have_prev_reg) |=> (state_reg == ST_CHECK && n_reg == '0))
        else $error("frame with held previous did not start a run");

    a_emit_bumps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && (!out_valid_reg || m_tready))
            |=> (out_valid_reg && n_reg == $past(n_inc)))
        else $error("beat load did not advance the count");

endmodule
